### design/fqkr_pkg.sv
// Package for the FIFO queue with keyed remove.
// Holds command and status codes, field widths and the per-cell control struct.
// No dependencies.
package fqkr_pkg;

  localparam int PID_W   = 22;
  localparam int CMD_W   = 2;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 5;

  // Command codes carried by in_command.
  localparam logic [CMD_W-1:0] CMD_PUSH   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_POP    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NONE   = 2'd3;

  // Status codes reported on out_status.
  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd3;

  // Control broadcast from the top level to every cell of the chain.
  typedef struct packed {
    logic             push;   // push accepted and store not full
    logic             pop;    // pop accepted and store not empty
    logic             rmv;    // remove accepted
    logic [PID_W-1:0] key;    // pid to push or key to match
  } cell_ctrl_t;

endpackage

### design/fqkr_cell.sv
// One storage cell of the queue chain: holds one pid, compares it to the key,
// and shifts in the next cell's pid when it or an entry ahead of it leaves.
// Depends on fqkr_pkg.
module fqkr_cell #(
  parameter int IDX     = 0,
  parameter int COUNT_W = 5
) (
  input  logic                      clk,
  input  fqkr_pkg::cell_ctrl_t      ctrl,
  input  logic [COUNT_W-1:0]        cnt,
  input  logic                      hit_in,
  input  logic [fqkr_pkg::PID_W-1:0] next_id,
  output logic                      hit_out,
  output logic [fqkr_pkg::PID_W-1:0] id,
  output logic [fqkr_pkg::PID_W-1:0] take_id
);
  import fqkr_pkg::*;

  logic [PID_W-1:0] id_r;
  logic [PID_W-1:0] id_nxt;
  logic             occupied;
  logic             is_tail;
  logic             match;
  logic             shift;

  // A cell holds a live entry when its position is below the count.
  assign occupied = COUNT_W'(IDX) < cnt;
  assign is_tail  = COUNT_W'(IDX) == cnt;

  // Match chain: the first matching cell is the one taken out.
  assign match   = ctrl.rmv & occupied & (id_r == ctrl.key);
  assign hit_out = hit_in | match;
  assign take_id = (match & ~hit_in) ? id_r : '0;

  // The cell closes the gap when it or an older cell leaves.
  assign shift = ctrl.pop | (ctrl.rmv & hit_out);

  always_comb begin
    id_nxt = id_r;
    if (shift) begin
      id_nxt = next_id;
    end else if (ctrl.push && is_tail) begin
      id_nxt = ctrl.key;
    end
  end

  always_ff @(posedge clk) begin
    id_r <= id_nxt;
  end

  assign id = id_r;

endmodule

### design/fifo_queue_with_keyed_remove_top.sv
// Each result is registered and appears in the cycle after its command transfer.
// Throughput: one command per cycle; busy stays low, as the whole cell chain
// compares, shifts and loads in the cycle a command is taken.
// Reset: synchronous, active low; the entry count and the result strobe clear.
// Stored pids are not cleared; only entries below the count are ever read.
module fifo_queue_with_keyed_remove_top #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [fqkr_pkg::CMD_W-1:0]    in_command,
  input  logic [fqkr_pkg::PID_W-1:0]    in_pid,
  output logic                          out_valid,
  output logic [fqkr_pkg::STAT_W-1:0]   out_status,
  output logic [fqkr_pkg::PID_W-1:0]    out_pid,
  output logic [fqkr_pkg::COUNT_W-1:0]  out_count
);
  import fqkr_pkg::*;

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic                accept;
  logic                empty;
  logic                full;
  logic                found;
  cell_ctrl_t          ctrl;
  logic [CW-1:0]       cnt_r;
  logic [CW-1:0]       cnt_nxt;
  logic [STAT_W-1:0]   status_nxt;
  logic [PID_W-1:0]    pid_nxt;
  logic [PID_W-1:0]    taken;
  logic                out_valid_r;
  logic [STAT_W-1:0]   out_status_r;
  logic [PID_W-1:0]    out_pid_r;
  logic [COUNT_W-1:0]  out_count_r;

  logic                hit   [QUEUE_DEPTH+1];
  logic [PID_W-1:0]    ids   [QUEUE_DEPTH+1];
  logic [PID_W-1:0]    takes [QUEUE_DEPTH];

  assign busy   = 1'b0;
  assign accept = start & ~busy;
  assign empty  = cnt_r == '0;
  assign full   = cnt_r == CW'(QUEUE_DEPTH);

  // Broadcast control to the chain.
  always_comb begin
    ctrl.push = accept && (in_command == CMD_PUSH) && !full;
    ctrl.pop  = accept && (in_command == CMD_POP) && !empty;
    ctrl.rmv  = accept && (in_command == CMD_REMOVE);
    ctrl.key  = in_pid;
  end

  // The chain of cells; the oldest entry sits in cell zero.
  assign hit[0]           = 1'b0;
  assign ids[QUEUE_DEPTH] = '0;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    fqkr_cell #(
      .IDX     (i),
      .COUNT_W (CW)
    ) u_cell (
      .clk     (clk),
      .ctrl    (ctrl),
      .cnt     (cnt_r),
      .hit_in  (hit[i]),
      .next_id (ids[i+1]),
      .hit_out (hit[i+1]),
      .id      (ids[i]),
      .take_id (takes[i])
    );
  end

  assign found = hit[QUEUE_DEPTH];

  // Only one cell reports a taken pid, so an OR gathers it.
  always_comb begin
    taken = '0;
    for (int k = 0; k < QUEUE_DEPTH; k++) begin
      taken = taken | takes[k];
    end
  end

  // Status, pid and next count for the command in flight.
  always_comb begin
    status_nxt = ST_OK;
    pid_nxt    = '0;
    cnt_nxt    = cnt_r;
    unique case (in_command)
      CMD_PUSH: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          cnt_nxt = cnt_r + CW'(1);
        end
      end
      CMD_POP: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          pid_nxt = ids[0];
          cnt_nxt = cnt_r - CW'(1);
        end
      end
      CMD_REMOVE: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else if (found) begin
          pid_nxt = taken;
          cnt_nxt = cnt_r - CW'(1);
        end else begin
          status_nxt = ST_NOTFOUND;
        end
      end
      CMD_NONE: begin
        status_nxt = ST_OK;
      end
      default: begin
        status_nxt = ST_OK;
      end
    endcase
  end

  // Count and result strobe.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= accept;
      if (accept) begin
        cnt_r <= cnt_nxt;
      end
    end
  end

  // Result payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      out_status_r <= status_nxt;
      out_pid_r    <= pid_nxt;
      out_count_r  <= COUNT_W'(cnt_nxt);
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_pid    = out_pid_r;
  assign out_count  = out_count_r;

endmodule

### design/fqkr_chk.sv
// Port-level checker for the FIFO queue with keyed remove, and its bind.
// Depends on fqkr_pkg and on fifo_queue_with_keyed_remove_top.
module fqkr_chk #(
  parameter int QUEUE_DEPTH = 16
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input logic                          out_valid,
  input logic [fqkr_pkg::STAT_W-1:0]   out_status,
  input logic [fqkr_pkg::PID_W-1:0]    out_pid,
  input logic [fqkr_pkg::COUNT_W-1:0]  out_count
);
  import fqkr_pkg::*;

  // Every transfer gives exactly one result in the next cycle.
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> out_valid)
    else $error("command transfer without a result");

  // No result appears without a command transfer.
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && !busy) |=> !out_valid)
    else $error("result without a command transfer");

  // A failed command returns a zero pid (a push does too, but is not checked here).
  a_pid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |-> out_pid == '0)
    else $error("nonzero pid on a failed command");

  // A dropped push reports the store as full.
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_FULL) |-> out_count == COUNT_W'(QUEUE_DEPTH))
    else $error("full status with a count below the depth");

  // Pop or remove on an empty store leaves the count at zero.
  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_EMPTY) |-> out_count == '0)
    else $error("empty status with a nonzero count");

endmodule

bind fifo_queue_with_keyed_remove_top fqkr_chk #(
  .QUEUE_DEPTH (QUEUE_DEPTH)
) u_fqkr_chk (.*);
